FILE: sv/assert_macros.svh
// Assertion macros for the shortest path matrix RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequent in the same cycle.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequent in the next cycle.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: sv/spm_pkg.sv
// Package for the shortest path matrix core: sizes, types and helpers.
// Depends on nothing; imported by the core top level and the testbench.
package spm_pkg;
	localparam int MaxVertices = 64;
	localparam int WeightBits = 16;
	localparam int VBits = $clog2(MaxVertices);
	localparam int AddrBits = 2 * VBits;
	localparam int DistBits = 32;
	localparam int CntBits = 7;
	localparam int VEntBits = DistBits + 2;
	localparam logic [DistBits-1:0] DistInf = '1;

	localparam logic KindLoad = 1'b0;
	localparam logic KindQuery = 1'b1;

	typedef logic [VBits-1:0] vtx_t;
	typedef logic [DistBits-1:0] dist_t;
	typedef logic [WeightBits-1:0] wgt_t;

	// Per-vertex entry of the vertex memory: flags and tentative distance.
	typedef struct packed {
		logic  settled;
		logic  reached;
		dist_t cost;
	} vent_t;

	// One-hot sequencer states.
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_INIT  = 10'b0000000010,
		ST_SCAN  = 10'b0000000100,
		ST_PICK  = 10'b0000001000,
		ST_RELAX = 10'b0000010000,
		ST_WALK  = 10'b0000100000,
		ST_WWAIT = 10'b0001000000,
		ST_EMIT  = 10'b0010000000,
		ST_FAIL  = 10'b0100000000,
		ST_CLEAR = 10'b1000000000
	} state_t;

	// Saturating distance sum.
	function automatic dist_t sat_add(dist_t a, wgt_t w);
		logic [DistBits:0] s;
		s = {1'b0, a} + {{(DistBits + 1 - WeightBits){1'b0}}, w};
		return s[DistBits] ? DistInf : s[DistBits-1:0];
	endfunction
endpackage

FILE: sv/spm_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
// Depends on nothing.
module spm_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/shortest_path_matrix_core.sv
// Shortest path matrix core top level: edge matrix, vertex, predecessor and
// path memories and the Dijkstra sequencer. Depends on spm_pkg, spm_ram and
// assert_macros.svh.
//
// A load transaction writes one edge weight. A query first writes the N
// vertex entries. Each settle step scans all N vertices and picks the
// least, then walks the settled row of the edge matrix; one more scan and
// pick finds nothing left. The walk back from the target then passes
// through ST_WALK and ST_WWAIT for each path vertex, and the output primes
// the path read and then gives one path vertex per transaction while it is
// not stalled. After reset the edge matrix is cleared by a pass over all
// 4096 entries during which no input transaction is accepted.
module shortest_path_matrix_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [5:0]           row,
	input  logic [5:0]           col,
	input  logic [15:0]          weight,
	input  logic [5:0]           source,
	input  logic [5:0]           dest,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [5:0]           vertex,
	output logic                 found,
	output logic                 last
);
	import spm_pkg::*;
	`include "assert_macros.svh"

	state_t state_q;
	logic [CntBits-1:0] nv_q, n_q;
	vtx_t src_q, dst_q, u_q, rv_q;
	logic [CntBits-1:0] i_q;
	logic [AddrBits:0] clr_q;
	logic have_q, dseen_q, pr_q;
	dist_t best_q, du_q;
	logic [CntBits-1:0] len_q, k_q;
	logic rd_v_s1;
	vtx_t rd_i_s1;
	vtx_t i_lo;
	assign i_lo = i_q[VBits-1:0];

	// Edge memory.
	logic e_we;
	logic [AddrBits-1:0] e_waddr, e_raddr;
	wgt_t e_wdata, e_rdata;
	spm_ram #(.Width(WeightBits), .Depth(MaxVertices * MaxVertices)) u_edge (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata));

	// Vertex, predecessor and path memories.
	logic d_we;
	vtx_t d_waddr, d_raddr;
	vent_t d_wdata, d_rdata;
	logic p_we;
	vtx_t p_waddr, p_raddr;
	vtx_t p_wdata, p_rdata;
	logic path_we;
	vtx_t path_waddr, path_raddr;
	vtx_t path_wdata, path_rdata;
	spm_ram #(.Width(VEntBits), .Depth(MaxVertices)) u_dist (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata));
	spm_ram #(.Width(VBits), .Depth(MaxVertices)) u_pred (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata));
	spm_ram #(.Width(VBits), .Depth(MaxVertices)) u_path (
		.clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
		.raddr(path_raddr), .rdata(path_rdata));

	logic [CntBits-1:0] n_eff;
	always_comb begin
		n_eff = nv_q;
		if (nv_q == '0) n_eff = CntBits'(1);
		if (nv_q > CntBits'(MaxVertices)) n_eff = CntBits'(MaxVertices);
	end

	logic out_pend;
	assign out_pend = out_valid && out_stall;
	assign in_stall = (state_q != ST_IDLE) || out_pend;
	logic in_acc;
	assign in_acc = in_valid && !in_stall;
	logic emit_go;
	assign emit_go = ((state_q == ST_EMIT) && pr_q && !out_pend)
		|| ((state_q == ST_FAIL) && !out_pend);

	// Scan candidate from the registered read of stage 1.
	logic cand, dst_hit;
	vtx_t pick_u;
	dist_t pick_d;
	assign cand = rd_v_s1 && d_rdata.reached && !d_rdata.settled
		&& (!have_q || d_rdata.cost < best_q);
	assign dst_hit = rd_v_s1 && (rd_i_s1 == dst_q) && d_rdata.reached;
	assign pick_u = cand ? rd_i_s1 : u_q;
	assign pick_d = cand ? d_rdata.cost : best_q;

	// Relax candidate from registered reads of stage 1.
	dist_t nd;
	logic relax_ok;
	assign nd = sat_add(du_q, e_rdata);
	assign relax_ok = rd_v_s1 && (e_rdata != '0) && !d_rdata.settled
		&& (!d_rdata.reached || nd < d_rdata.cost);

	// Memory ports.
	always_comb begin
		e_we = 1'b0;
		e_waddr = {row, col};
		e_wdata = weight;
		e_raddr = {u_q, i_lo};
		d_we = 1'b0;
		d_waddr = i_lo;
		d_wdata.settled = 1'b0;
		d_wdata.reached = 1'b0;
		d_wdata.cost = DistInf;
		d_raddr = i_lo;
		p_we = 1'b0;
		p_waddr = i_lo;
		p_wdata = '0;
		p_raddr = rv_q;
		path_we = 1'b0;
		path_waddr = len_q[VBits-1:0];
		path_wdata = rv_q;
		path_raddr = k_q[VBits-1:0];
		case (state_q)
			ST_CLEAR: begin
				e_we = 1'b1;
				e_waddr = clr_q[AddrBits-1:0];
				e_wdata = '0;
			end
			ST_IDLE: begin
				e_we = in_acc && (kind == KindLoad);
			end
			ST_INIT: begin
				d_we = 1'b1;
				d_wdata.reached = (i_lo == src_q);
				d_wdata.cost = (i_lo == src_q) ? '0 : DistInf;
				p_we = 1'b1;
			end
			ST_PICK: begin
				d_we = have_q || cand;
				d_waddr = pick_u;
				d_wdata.settled = 1'b1;
				d_wdata.reached = 1'b1;
				d_wdata.cost = pick_d;
			end
			ST_RELAX: begin
				d_we = relax_ok;
				d_waddr = rd_i_s1;
				d_wdata.reached = 1'b1;
				d_wdata.cost = nd;
				p_we = relax_ok;
				p_waddr = rd_i_s1;
				p_wdata = u_q;
			end
			ST_WALK: begin
				path_we = 1'b1;
			end
			ST_EMIT: begin
				if (emit_go && k_q != '0) path_raddr = k_q[VBits-1:0] - 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			nv_q <= CntBits'(MaxVertices);
			clr_q <= '0;
			out_valid <= 1'b0;
			rd_v_s1 <= 1'b0;
			pr_q <= 1'b0;
		end else begin
			if (cfg_we) nv_q <= cfg_wdata;
			out_valid <= emit_go || out_pend;
			rd_v_s1 <= (state_q == ST_SCAN) || ((state_q == ST_RELAX) && (i_q != n_q));
			rd_i_s1 <= i_lo;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AddrBits+1)'(MaxVertices * MaxVertices - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc && kind == KindQuery) begin
						n_q <= n_eff;
						src_q <= source;
						dst_q <= dest;
						i_q <= '0;
						if ({1'b0, source} >= n_eff || {1'b0, dest} >= n_eff)
							state_q <= ST_FAIL;
						else
							state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (i_q == n_q - 1'b1) begin
						i_q <= '0;
						have_q <= 1'b0;
						dseen_q <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_SCAN: begin
					// Issue read at i_q; compare the previous read.
					if (cand) begin
						have_q <= 1'b1;
						best_q <= d_rdata.cost;
						u_q <= rd_i_s1;
					end
					if (dst_hit) dseen_q <= 1'b1;
					if (i_q == n_q - 1'b1) state_q <= ST_PICK;
					else i_q <= i_q + 1'b1;
				end
				ST_PICK: begin
					if (!(have_q || cand)) begin
						state_q <= (dseen_q || dst_hit) ? ST_WALK : ST_FAIL;
						rv_q <= dst_q;
						len_q <= '0;
					end else begin
						u_q <= pick_u;
						du_q <= pick_d;
						i_q <= '0;
						state_q <= ST_RELAX;
					end
				end
				ST_RELAX: begin
					// Read edge and distance at i_q; decide on the previous one.
					if (i_q == n_q) begin
						i_q <= '0;
						have_q <= 1'b0;
						dseen_q <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_WALK: begin
					len_q <= len_q + 1'b1;
					if (rv_q == src_q || len_q + 1'b1 == n_q) begin
						k_q <= len_q;
						pr_q <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_WWAIT;
					end
				end
				ST_WWAIT: begin
					rv_q <= p_rdata;
					state_q <= ST_WALK;
				end
				ST_EMIT: begin
					// Prime the path read, then advance one vertex per transaction.
					if (!pr_q) begin
						pr_q <= 1'b1;
					end else if (emit_go) begin
						vertex <= path_rdata;
						found <= 1'b1;
						last <= (k_q == '0);
						if (k_q == '0) state_q <= ST_IDLE;
						else k_q <= k_q - 1'b1;
					end
				end
				ST_FAIL: begin
					if (emit_go) begin
						vertex <= dst_q;
						found <= 1'b0;
						last <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks.
	`AST_IMPLY(a_clear_stall, clk, arst_n, state_q == ST_CLEAR, in_stall)
	`AST_NEXT(a_out_hold, clk, arst_n, out_pend,
		out_valid && $stable(vertex) && $stable(found) && $stable(last))
	`AST_NEXT(a_fail_last, clk, arst_n, state_q == ST_FAIL && !out_pend,
		out_valid && last && !found)
endmodule

FILE: verif/tb_top.sv
// Testbench for shortest_path_matrix_core: edge loads and path queries
// checked against a Dijkstra predictor. Depends on spm_pkg and the core RTL.
import spm_pkg::*;

typedef struct packed {
	logic kind;
	vtx_t row;
	vtx_t col;
	wgt_t weight;
	vtx_t source;
	vtx_t dest;
} graph_op_t;

typedef struct packed {
	vtx_t vertex;
	logic found;
	logic last;
} path_step_t;

class path_scoreboard;
	wgt_t edge_mem [MaxVertices][MaxVertices];
	int unsigned vcount;
	path_step_t expected_steps[$];
	int errors;
	int checked;

	function new();
		foreach (edge_mem[i, j]) edge_mem[i][j] = '0;
		vcount = MaxVertices;
		errors = 0;
		checked = 0;
	endfunction

	function void set_vcount(logic [6:0] v);
		vcount = 32'(v);
	endfunction

	function int pending();
		return expected_steps.size();
	endfunction

	function void push_step(vtx_t v, logic f, logic l);
		path_step_t s;
		s.vertex = v;
		s.found = f;
		s.last = l;
		expected_steps = {expected_steps, s};
	endfunction

	// Apply a load, or run Dijkstra and queue the expected path.
	function void note_op(graph_op_t op);
		int unsigned n;
		int unsigned u;
		logic [DistBits:0] sum;
		dist_t dist_est [MaxVertices];
		vtx_t pred [MaxVertices];
		bit done [MaxVertices];
		bit seen [MaxVertices];
		vtx_t walk[$];
		vtx_t v;
		bit have;
		if (op.kind == KindLoad) begin
			edge_mem[op.row][op.col] = op.weight;
			return;
		end
		n = (vcount < 1) ? 1 : (vcount > MaxVertices) ? MaxVertices : vcount;
		if (op.source >= n || op.dest >= n) begin
			push_step(op.dest, 1'b0, 1'b1);
			return;
		end
		for (int i = 0; i < MaxVertices; i++) begin
			dist_est[i] = DistInf;
			pred[i] = '0;
			done[i] = 0;
			seen[i] = 0;
		end
		dist_est[op.source] = '0;
		seen[op.source] = 1;
		forever begin
			have = 0;
			u = 0;
			// Pick the open vertex of least distance, lowest index on ties
			for (int i = 0; i < n; i++)
				if (seen[i] && !done[i] && (!have || dist_est[i] < dist_est[u])) begin
					u = i;
					have = 1;
				end
			if (!have) break;
			done[u] = 1;
			// Relax the row of the settled vertex
			for (int j = 0; j < n; j++) begin
				if (edge_mem[u][j] == '0 || done[j]) continue;
				sum = {1'b0, dist_est[u]} + edge_mem[u][j];
				if (sum[DistBits]) sum[DistBits-1:0] = DistInf;
				if (!seen[j] || sum[DistBits-1:0] < dist_est[j]) begin
					dist_est[j] = sum[DistBits-1:0];
					pred[j] = vtx_t'(u);
					seen[j] = 1;
				end
			end
		end
		if (!seen[op.dest]) begin
			push_step(op.dest, 1'b0, 1'b1);
			return;
		end
		// Walk back from the target, bounded by the vertex count
		v = op.dest;
		while (walk.size() < n) begin
			walk.push_front(v);
			if (v == op.source) break;
			v = pred[v];
		end
		foreach (walk[k]) push_step(walk[k], 1'b1, k == walk.size() - 1);
	endfunction

	task report(string what);
		errors++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task check_step(vtx_t v, logic f, logic l);
		path_step_t e;
		checked++;
		if (expected_steps.size() == 0) begin
			report($sformatf("unexpected result vertex=%0d found=%0b last=%0b", v, f, l));
			return;
		end
		e = expected_steps.pop_front();
		if (v !== e.vertex) report($sformatf("vertex %0d, want %0d", v, e.vertex));
		if (f !== e.found) report($sformatf("found %0b, want %0b", f, e.found));
		if (l !== e.last) report($sformatf("last %0b, want %0b", l, e.last));
	endtask
endclass

module tb_top;
	localparam int IdleLimit = 60000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [5:0] row = '0, col = '0, source = '0, dest = '0;
	logic [15:0] weight = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] vertex;
	logic found, last;

	path_scoreboard sb = new();
	int idle_cycles = 0;
	int ops_sent = 0;
	bit steady = 0;

	shortest_path_matrix_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .row(row), .col(col), .weight(weight),
		.source(source), .dest(dest),
		.out_valid(out_valid), .out_stall(out_stall),
		.vertex(vertex), .found(found), .last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 19);
		if (steady || r < 10) return 0;
		if (r < 16) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// Hold the transaction until the core takes it
	task automatic send_op(graph_op_t op);
		int gap;
		gap = rand_gap();
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= op.kind;
		row <= op.row;
		col <= op.col;
		weight <= op.weight;
		source <= op.source;
		dest <= op.dest;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_op(op);
		ops_sent++;
	endtask

	task automatic load_edge(int r, int c, wgt_t w);
		graph_op_t op;
		op = '0;
		op.kind = KindLoad;
		op.row = vtx_t'(r);
		op.col = vtx_t'(c);
		op.weight = w;
		send_op(op);
	endtask

	task automatic query_path(int s, int d);
		graph_op_t op;
		op = graph_op_t'($bits(graph_op_t)'({$urandom, $urandom}));
		op.kind = KindQuery;
		op.source = vtx_t'(s);
		op.dest = vtx_t'(d);
		send_op(op);
	endtask

	// Drain all expected results, then let the core settle
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_vcount(logic [6:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk) cfg_we <= 1'b0;
		sb.set_vcount(v);
	endtask

	task automatic random_ops(int count, int n, int max_queries);
		int queries;
		int span;
		queries = 0;
		span = (n < 1) ? 1 : (n > MaxVertices) ? MaxVertices : n;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2 && n == 12) drain();
			if ($urandom_range(0, 9) < 3 && queries < max_queries) begin
				queries++;
				if ($urandom_range(0, 9) < 8)
					query_path($urandom_range(0, span - 1), $urandom_range(0, span - 1));
				else
					query_path($urandom, $urandom);
			end else if ($urandom_range(0, 9) < 8) begin
				load_edge($urandom_range(0, span - 1), $urandom_range(0, span - 1),
					($urandom_range(0, 5) == 0) ? 16'h0 : 16'($urandom));
			end else begin
				load_edge($urandom, $urandom, 16'($urandom));
			end
		end
	endtask

	// Sample results on the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_step(vertex, found, last);
	end

	// Random back-pressure on the result side
	initial begin
		int r;
		forever begin
			r = $urandom_range(0, 19);
			@(negedge clk) out_stall <= (!steady && r >= 12);
			if (r == 19) repeat ($urandom_range(10, 40)) @(negedge clk);
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: detour beats heavy direct edge, extremes, special cases
		load_edge(0, 63, 16'hFFFF);
		load_edge(63, 0, 16'h0001);
		load_edge(0, 1, 16'h0005);
		load_edge(1, 63, 16'h0007);
		query_path(0, 63);
		query_path(5, 5);
		query_path(0, 10);
		load_edge(1, 63, 16'h0000);
		query_path(0, 63);
		load_edge(2, 2, 16'h0009);
		load_edge(2, 3, 16'h0004);
		load_edge(2, 4, 16'h0002);
		load_edge(4, 3, 16'h0002);
		query_path(2, 3);
		write_vcount(7'd8);
		query_path(63, 2);
		query_path(2, 8);
		query_path(4, 0);
		query_path(2, 3);
		write_vcount(7'd0);
		query_path(0, 0);
		query_path(0, 1);
		write_vcount(7'd127);
		query_path(63, 1);

		// Random phases across vertex counts
		write_vcount(7'd6);
		random_ops(24, 6, 10);
		steady = 1;
		write_vcount(7'd1);
		random_ops(12, 1, 6);
		steady = 0;
		write_vcount(7'd12);
		random_ops(30, 12, 10);
		write_vcount(7'd3);
		random_ops(16, 3, 6);
		write_vcount(7'd64);
		random_ops(14, 64, 2);
		write_vcount(7'd10);
		random_ops(24, 10, 10);
		drain();
		repeat (100) @(posedge clk);

		$display("sent %0d transactions at vertex counts 0..127, %0d results checked",
			ops_sent, sb.checked);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

FILE: shortest_path_matrix_core.f
+incdir+sv
sv/spm_pkg.sv
sv/spm_ram.sv
sv/shortest_path_matrix_core.sv
verif/tb_top.sv
